### design/cfr_pkg.sv
// Shared types, command codes and the command decode for the command frame receiver.
package cfr_pkg;

	localparam int unsigned STORE_DEPTH = 24;
	localparam int unsigned COUNT_W     = 6;
	localparam int unsigned NUM_WORDS   = 5;
	localparam int unsigned WORD_BASE   = 4;

	// Command byte codes
	localparam logic [7:0] CMD_STOP        = 8'h01;
	localparam logic [7:0] CMD_MOVE_DIST   = 8'h02;
	localparam logic [7:0] CMD_ARM_JOINTS  = 8'h03;
	localparam logic [7:0] CMD_CLAW        = 8'h04;
	localparam logic [7:0] CMD_TRAY        = 8'h05;
	localparam logic [7:0] CMD_MOVE_VEL    = 8'h07;
	localparam logic [7:0] CMD_ARM_POS     = 8'h08;

	// Command kind codes on the result
	localparam logic [2:0] KIND_STOP       = 3'd0;
	localparam logic [2:0] KIND_MOVE_DIST  = 3'd1;
	localparam logic [2:0] KIND_ARM_JOINTS = 3'd2;
	localparam logic [2:0] KIND_CLAW       = 3'd3;
	localparam logic [2:0] KIND_TRAY       = 3'd4;
	localparam logic [2:0] KIND_MOVE_VEL   = 3'd5;
	localparam logic [2:0] KIND_ARM_POS    = 3'd6;

	// Register indexes
	localparam logic REG_START_BYTE     = 1'b0;
	localparam logic REG_DEVICE_ADDRESS = 1'b1;

	localparam logic [7:0] START_BYTE_RST     = 8'h7A;
	localparam logic [7:0] DEVICE_ADDRESS_RST = 8'h01;

	typedef struct packed {
		logic        known;
		logic [2:0]  kind;
	} kind_lookup_t;

	typedef struct packed {
		logic [2:0]  command_kind;
		logic [31:0] word0;
		logic [31:0] word1;
		logic [31:0] word2;
		logic [31:0] word3;
		logic [31:0] word4;
	} result_t;

	function automatic kind_lookup_t kind_of(input logic [7:0] cmd);
		kind_lookup_t r;
		r.known = 1'b1;
		unique case (cmd)
			CMD_STOP:       r.kind = KIND_STOP;
			CMD_MOVE_DIST:  r.kind = KIND_MOVE_DIST;
			CMD_ARM_JOINTS: r.kind = KIND_ARM_JOINTS;
			CMD_CLAW:       r.kind = KIND_CLAW;
			CMD_TRAY:       r.kind = KIND_TRAY;
			CMD_MOVE_VEL:   r.kind = KIND_MOVE_VEL;
			CMD_ARM_POS:    r.kind = KIND_ARM_POS;
			default: begin
				r.known = 1'b0;
				r.kind  = KIND_STOP;
			end
		endcase
		return r;
	endfunction

endpackage

### design/cfr_if.sv
// Valid/ready channel interfaces for received bytes and decoded commands.
interface cfr_in_if;
	logic       valid;
	logic       ready;
	logic       mode;
	logic [7:0] rx_byte;

	modport source (output valid, output mode, output rx_byte, input ready);
	modport sink   (input valid, input mode, input rx_byte, output ready);
endinterface

interface cfr_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  command_kind;
	logic [31:0] word0;
	logic [31:0] word1;
	logic [31:0] word2;
	logic [31:0] word3;
	logic [31:0] word4;

	modport source (output valid, output command_kind, output word0, output word1,
		output word2, output word3, output word4, input ready);
	modport sink   (input valid, input command_kind, input word0, input word1,
		input word2, input word3, input word4, output ready);
endinterface

### design/cfr_out_buffer.sv
// Two-entry result buffer: output register plus skid stage.
module cfr_out_buffer (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  cfr_pkg::result_t push_data,
	output logic             has_room,
	output logic             out_valid,
	input  logic             out_ready,
	output cfr_pkg::result_t out_data
);

	logic             main_valid_q;
	logic             skid_valid_q;
	cfr_pkg::result_t main_q;
	cfr_pkg::result_t skid_q;
	logic             advance;

	assign advance   = !main_valid_q || out_ready;
	assign has_room  = !skid_valid_q;
	assign out_valid = main_valid_q;
	assign out_data  = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (advance) begin
			// push never coincides with a full skid stage
			main_valid_q <= skid_valid_q || push;
			skid_valid_q <= 1'b0;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			main_q <= skid_valid_q ? skid_q : push_data;
		end else if (push) begin
			skid_q <= push_data;
		end
	end

endmodule

### design/command_frame_receiver.sv
// Top level of the command frame receiver.
// Takes one beat per cycle on rx: a data byte (mode 0) or an idle-line event (mode 1).
// Data bytes update the frame state in the cycle they are accepted; an idle beat checks
// the frame (length, overflow, start byte, device address, checksum), decodes the command
// byte and loads the result into a two-entry output buffer, so one beat per clock is
// sustained and a waiting result does not stall the input until the skid stage also
// fills. A result is registered in the output register, or in the skid stage while
// the output holds an untaken result. Frame state clears at once on every idle beat.
module command_frame_receiver #(
	parameter int unsigned FRAME_CAPACITY = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	cfr_in_if.sink     rx,
	cfr_out_if.source  cmd,
	input  logic       cfg_write,
	input  logic       cfg_index,
	input  logic [7:0] cfg_wdata
);

	localparam logic [cfr_pkg::COUNT_W-1:0] CAP = cfr_pkg::COUNT_W'(FRAME_CAPACITY);

	logic [7:0]                  start_byte_q;
	logic [7:0]                  device_address_q;
	logic [7:0]                  store_q [cfr_pkg::STORE_DEPTH];
	logic [cfr_pkg::COUNT_W-1:0] count_q;
	logic [7:0]                  sum_q;
	logic [7:0]                  final_q;
	logic                        overflow_q;

	logic                        accept;
	logic                        data_beat;
	logic                        idle_beat;
	logic                        at_capacity;
	logic [7:0]                  rd_byte [cfr_pkg::STORE_DEPTH];
	cfr_pkg::kind_lookup_t       lookup;
	logic                        frame_ok;
	logic                        emit;
	logic                        has_room;
	cfr_pkg::result_t            result;
	cfr_pkg::result_t            out_data;

	assign rx.ready    = has_room;
	assign accept      = rx.valid && has_room;
	assign data_beat   = accept && !rx.mode;
	assign idle_beat   = accept && rx.mode;
	assign at_capacity = count_q >= CAP;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_byte_q     <= cfr_pkg::START_BYTE_RST;
			device_address_q <= cfr_pkg::DEVICE_ADDRESS_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				cfr_pkg::REG_START_BYTE:     start_byte_q     <= cfg_wdata;
				cfr_pkg::REG_DEVICE_ADDRESS: device_address_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			sum_q      <= '0;
			final_q    <= '0;
			overflow_q <= 1'b0;
		end else if (idle_beat) begin
			count_q    <= '0;
			sum_q      <= '0;
			final_q    <= '0;
			overflow_q <= 1'b0;
		end else if (data_beat) begin
			if (at_capacity) begin
				overflow_q <= 1'b1;
			end else begin
				count_q <= count_q + 1'b1;
				sum_q   <= sum_q + final_q;
				final_q <= rx.rx_byte;
			end
		end
	end

	// Store bytes in arrival order; entries at or beyond the count read as zero.
	always_ff @(posedge clk) begin
		for (int i = 0; i < cfr_pkg::STORE_DEPTH; i++) begin
			if (data_beat && count_q == cfr_pkg::COUNT_W'(i)) begin
				store_q[i] <= rx.rx_byte;
			end
		end
	end

	always_comb begin
		for (int i = 0; i < cfr_pkg::STORE_DEPTH; i++) begin
			rd_byte[i] = (cfr_pkg::COUNT_W'(i) < count_q) ? store_q[i] : 8'h00;
		end
	end

	assign lookup   = cfr_pkg::kind_of(rd_byte[2]);
	assign frame_ok = (count_q >= cfr_pkg::COUNT_W'(2)) && !overflow_q
		&& (rd_byte[0] == start_byte_q) && (rd_byte[1] == device_address_q)
		&& (sum_q == final_q);
	assign emit     = idle_beat && frame_ok && lookup.known;

	always_comb begin
		result.command_kind = lookup.kind;
		result.word0 = {rd_byte[7],  rd_byte[6],  rd_byte[5],  rd_byte[4]};
		result.word1 = {rd_byte[11], rd_byte[10], rd_byte[9],  rd_byte[8]};
		result.word2 = {rd_byte[15], rd_byte[14], rd_byte[13], rd_byte[12]};
		result.word3 = {rd_byte[19], rd_byte[18], rd_byte[17], rd_byte[16]};
		result.word4 = {rd_byte[23], rd_byte[22], rd_byte[21], rd_byte[20]};
	end

	cfr_out_buffer u_out_buffer (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (emit),
		.push_data (result),
		.has_room  (has_room),
		.out_valid (cmd.valid),
		.out_ready (cmd.ready),
		.out_data  (out_data)
	);

	assign cmd.command_kind = out_data.command_kind;
	assign cmd.word0        = out_data.word0;
	assign cmd.word1        = out_data.word1;
	assign cmd.word2        = out_data.word2;
	assign cmd.word3        = out_data.word3;
	assign cmd.word4        = out_data.word4;

endmodule
